[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define MBROT_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define MBROT_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[src/mbrot_pkg.sv]
`timescale 1ns / 1ps

package mbrot_pkg;

    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ITER_W     = 16;
    localparam int STEP_W     = 31;
    localparam int TH_W       = 31;
    localparam int MOD_W      = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_X_MIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_MAX     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_X_STEP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_STEP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd5;

    localparam logic signed [MUL_W-1:0] RST_X_MIN     = -32'sd536870912;
    localparam logic signed [MUL_W-1:0] RST_Y_MAX     = 32'sd268435456;
    localparam logic [STEP_W-1:0]       RST_X_STEP    = 31'd805306;
    localparam logic [STEP_W-1:0]       RST_Y_STEP    = 31'd536871;
    localparam logic [ITER_W-1:0]       RST_MAX_ITER  = 16'd2000;
    localparam logic [TH_W-1:0]         RST_THRESHOLD = 31'd1073741824;

    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    localparam logic [MOD_W-1:0] MOD_LAST = 5'd19;
    localparam logic [MOD_W-1:0] MOD_HALF = 5'd10;
    localparam int PAL_BASE = 255;
    localparam int PAL_STEP = 10;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mbrot_mul_req_t;

    function automatic logic [7:0] palette_byte(input logic [MOD_W-1:0] m);
        palette_byte = 8'(PAL_BASE - PAL_STEP * int'(m));
    endfunction

endpackage

[src/mbrot_mul.sv]
`timescale 1ns / 1ps

module mbrot_mul (
    input  logic                                  aclk,
    input  mbrot_pkg::mbrot_mul_req_t             req,
    output logic signed [mbrot_pkg::PROD_W-1:0]   prod
);
    import mbrot_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // signed 32x32, registered
    assign prod_next = PROD_W'($signed(req.a)) * PROD_W'($signed(req.b));

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[src/mandelbrot_escape_time_pixel.sv]
// A result is produced when the iteration limit is reached, on the squared-modulus
// escape, or on the per-part bound escape; one shared 32x32 multiplier, with setup
// in states S_CR, S_CI, S_TH and each complex step in S_CHK, S_RR, S_II, S_RI,
// S_AR, S_AI, S_SQ.
// One pixel in flight; s_ready returns in the same cycle m_valid rises (later while a
// prior result is still held). Reset (sync, active low) clears control, loads config.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mbrot_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mbrot_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [COORD_BITS-1:0]               s_pixel_x,
    input  logic [COORD_BITS-1:0]               s_pixel_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [COUNT_BITS-1:0]               m_escape_count,
    output logic [7:0]                          m_green,
    output logic [7:0]                          m_red
);
    import mbrot_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR   = 4'd1;
    localparam logic [3:0] S_CI   = 4'd2;
    localparam logic [3:0] S_TH   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_RR   = 4'd5;
    localparam logic [3:0] S_II   = 4'd6;
    localparam logic [3:0] S_RI   = 4'd7;
    localparam logic [3:0] S_AR   = 4'd8;
    localparam logic [3:0] S_AI   = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;
    localparam logic [3:0] S_SQ   = 4'd11;

    // config
    logic signed [MUL_W-1:0] x_min_reg, y_max_reg;
    logic [STEP_W-1:0]       x_step_reg, y_step_reg;
    logic [ITER_W-1:0]       max_iter_reg;
    logic [TH_W-1:0]         th_reg;

    // datapath
    logic [3:0]               state_reg, state_next;
    logic [COORD_BITS-1:0]    py_reg;
    logic signed [MUL_W-1:0]  cr_reg, ci_reg, zr_reg, zi_reg;
    logic [MUL_W-1:0]         ar_reg, ai_reg;
    logic [PROD_W-1:0]        th_sq_reg, arsq_reg;
    logic signed [PROD_W-1:0] rr_reg, diff_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [COUNT_BITS-1:0]    cnt_reg, cnt_inc;
    logic [MOD_W-1:0]         m20_reg, m20_inc;
    logic [COUNT_BITS-1:0]    res_cnt_reg;
    logic [MOD_W-1:0]         res_m20_reg;

    // output register
    logic                     m_valid_reg;
    logic [COUNT_BITS-1:0]    out_cnt_reg;
    logic [7:0]               out_green_reg, out_red_reg;

    mbrot_mul_req_t           mul_req;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] nr, ni, xsum, ysum;
    logic [PROD_W-1:0]        ar, ai, sq_sum;
    logic                     bound_esc, sq_esc, out_free;
    logic [MOD_W-1:0]         res_m10;

    mbrot_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    function automatic logic signed [MUL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > SAT_MAX) begin
            sat32 = MUL_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            sat32 = MUL_W'(SAT_MIN);
        end else begin
            sat32 = MUL_W'(v);
        end
    endfunction

    assign xsum = PROD_W'(x_min_reg) + prod;
    assign ysum = PROD_W'(y_max_reg) - prod;

    // floor shifts; prod holds zr*zi in S_RI
    assign nr = (diff_reg >>> FRAC_BITS) + PROD_W'(cr_reg);
    assign ni = (prod >>> (FRAC_BITS - 1)) + PROD_W'(ci_reg);
    assign ar = nr[PROD_W-1] ? PROD_W'(-nr) : PROD_W'(nr);
    assign ai = ni[PROD_W-1] ? PROD_W'(-ni) : PROD_W'(ni);
    assign bound_esc = (ar > PROD_W'(th_reg)) || (ai > PROD_W'(th_reg));
    assign sq_sum = arsq_reg + PROD_W'(prod);
    assign sq_esc = sq_sum > th_sq_reg;

    assign cnt_inc = cnt_reg + COUNT_BITS'(1);
    assign m20_inc = (cnt_inc == '0) ? '0 :
                     (m20_reg == MOD_LAST) ? '0 : m20_reg + MOD_W'(1);
    assign res_m10 = (res_m20_reg >= MOD_HALF) ? res_m20_reg - MOD_HALF : res_m20_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        mul_req = '0;
        unique case (state_reg)
            S_IDLE: begin
                mul_req.a = MUL_W'(x_step_reg);
                mul_req.b = MUL_W'(s_pixel_x);
            end
            S_CR: begin
                mul_req.a = MUL_W'(y_step_reg);
                mul_req.b = MUL_W'(py_reg);
            end
            S_CI: begin
                mul_req.a = MUL_W'(th_reg);
                mul_req.b = MUL_W'(th_reg);
            end
            S_CHK: begin
                mul_req.a = zr_reg;
                mul_req.b = zr_reg;
            end
            S_RR: begin
                mul_req.a = zi_reg;
                mul_req.b = zi_reg;
            end
            S_II: begin
                mul_req.a = zr_reg;
                mul_req.b = zi_reg;
            end
            S_AR: begin
                mul_req.a = ar_reg;
                mul_req.b = ar_reg;
            end
            S_AI: begin
                mul_req.a = ai_reg;
                mul_req.b = ai_reg;
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_CR;
            S_CR:   state_next = S_CI;
            S_CI:   state_next = S_TH;
            S_TH:   state_next = S_CHK;
            S_CHK:  state_next = (iter_reg == max_iter_reg) ? S_DONE : S_RR;
            S_RR:   state_next = S_II;
            S_II:   state_next = S_RI;
            S_RI:   state_next = bound_esc ? S_DONE : S_AR;
            S_AR:   state_next = S_AI;
            S_AI:   state_next = S_SQ;
            S_SQ:   state_next = sq_esc ? S_DONE : S_CHK;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            x_min_reg    <= RST_X_MIN;
            y_max_reg    <= RST_Y_MAX;
            x_step_reg   <= RST_X_STEP;
            y_step_reg   <= RST_Y_STEP;
            max_iter_reg <= RST_MAX_ITER;
            th_reg       <= RST_THRESHOLD;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_X_MIN:     x_min_reg    <= cfg_wdata;
                    REG_Y_MAX:     y_max_reg    <= cfg_wdata;
                    REG_X_STEP:    x_step_reg   <= cfg_wdata[STEP_W-1:0];
                    REG_Y_STEP:    y_step_reg   <= cfg_wdata[STEP_W-1:0];
                    REG_MAX_ITER:  max_iter_reg <= cfg_wdata[ITER_W-1:0];
                    REG_THRESHOLD: th_reg       <= cfg_wdata[TH_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                py_reg <= s_pixel_y;
            end
            S_CR: cr_reg <= sat32(xsum);
            S_CI: ci_reg <= sat32(ysum);
            S_TH: begin
                th_sq_reg <= PROD_W'(prod);
                zr_reg    <= '0;
                zi_reg    <= '0;
                iter_reg  <= '0;
                cnt_reg   <= COUNT_BITS'(1);
                m20_reg   <= MOD_W'(1);
            end
            S_CHK: begin
                res_cnt_reg <= '0;
                res_m20_reg <= '0;
            end
            S_RR: rr_reg <= prod;
            S_II: diff_reg <= rr_reg - prod;
            S_RI: begin
                zr_reg      <= nr[MUL_W-1:0];
                zi_reg      <= ni[MUL_W-1:0];
                ar_reg      <= ar[MUL_W-1:0];
                ai_reg      <= ai[MUL_W-1:0];
                res_cnt_reg <= cnt_reg;
                res_m20_reg <= m20_reg;
            end
            S_AI: arsq_reg <= PROD_W'(prod);
            S_SQ: begin
                if (!sq_esc) begin
                    iter_reg <= iter_reg + ITER_W'(1);
                    cnt_reg  <= cnt_inc;
                    m20_reg  <= m20_inc;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_cnt_reg   <= res_cnt_reg;
                    out_green_reg <= (res_cnt_reg == '0) ? 8'd0 : palette_byte(res_m20_reg);
                    out_red_reg   <= (res_cnt_reg == '0) ? 8'd0 : palette_byte(res_m10);
                end
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_escape_count = out_cnt_reg;
    assign m_green        = out_green_reg;
    assign m_red          = out_red_reg;

    `MBROT_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == S_CR)
    `MBROT_ASSERT_NXT(a_done_loads, aclk, aresetn, state_reg == S_DONE && out_free, m_valid)
    `MBROT_ASSERT_IMP(a_iter_bound, aclk, aresetn, state_reg == S_RR, iter_reg < max_iter_reg)
    `MBROT_ASSERT_IMP(a_zero_black, aclk, aresetn, m_valid && m_escape_count == '0,
                      m_green == 8'd0 && m_red == 8'd0)

endmodule
